// File: src/wstd_pkg.sv
// ----------------------------------------------------------------------------
// wstd_pkg: shared types and constants for the work-stealing dispatcher
// Payload words, front/back queue entry and back-end state encoding.
// ----------------------------------------------------------------------------
package wstd_pkg;

	localparam int NUM_WORKERS_DEF  = 4;
	localparam int QUEUE_DEPTH_DEF  = 16;
	localparam int TASK_ID_BITS_DEF = 16;

	localparam logic MODE_ENQ   = 1'b0;
	localparam logic MODE_FETCH = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [15:0] task_id;
		logic [1:0]  worker_index;
	} in_word_t;

	typedef struct packed {
		logic        accepted;
		logic [15:0] task_out;
		logic [1:0]  queue_used;
		logic        stolen;
		logic        any_pending;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_READ,
		ST_DONE
	} back_state_t;

endpackage

// File: src/wstd_front.sv
// ----------------------------------------------------------------------------
// wstd_front: command front end
// Takes words on start, masks the task id and pushes them into a two-entry
// queue toward the back end.
// ----------------------------------------------------------------------------
module wstd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  wstd_pkg::in_word_t in_word,
	output logic               busy,
	output logic               q_valid,
	output wstd_pkg::in_word_t q_word,
	input  logic               q_pop
);
	import wstd_pkg::*;

	parameter int TASK_ID_BITS = TASK_ID_BITS_DEF;

	localparam int MB = (TASK_ID_BITS < 16) ? TASK_ID_BITS : 16;

	in_word_t   fifo_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push;
	in_word_t   masked;

	always_comb begin
		masked = in_word;
		masked.task_id = in_word.task_id & 16'((17'd1 << MB) - 17'd1);
	end

	assign busy    = (cnt_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_word  = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= masked;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

// File: src/wstd_back.sv
// ----------------------------------------------------------------------------
// wstd_back: queue engine
// Holds per-worker head/count and the task store memory; performs enqueue,
// own pop and a one-queue-per-cycle steal probe.
// ----------------------------------------------------------------------------
module wstd_back #(
	parameter int NUM_WORKERS = wstd_pkg::NUM_WORKERS_DEF,
	parameter int QUEUE_DEPTH = wstd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  wstd_pkg::in_word_t  q_word,
	output logic                q_pop,
	output logic                done,
	output wstd_pkg::out_word_t result
);
	import wstd_pkg::*;

	localparam int WB = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
	localparam int QB = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CB = $clog2(QUEUE_DEPTH + 1);
	localparam int SB = WB + QB;

	// address is {worker, slot}, so each worker owns a power-of-two region
	logic [15:0] store_q [NUM_WORKERS << QB];
	logic [QB-1:0] head_q [NUM_WORKERS];
	logic [CB-1:0] count_q [NUM_WORKERS];
	logic [WB-1:0] target_q;

	back_state_t st_q, st_d;
	in_word_t    cmd_q;
	logic [WB-1:0] probe_q, probe_d, used_q, used_d;
	logic [WB:0]   left_q, left_d;
	logic          stl_q, stl_d, acc_q, acc_d;
	logic          take, take_back, do_enq, rd_en;
	logic [SB-1:0] rd_addr, wr_addr;
	logic [15:0]   rd_data_q;
	logic [WB:0]   widx_ext;
	logic [WB-1:0] widx_base;
	logic          own_ok;
	logic [QB-1:0] slot;
	logic          pend;

	function automatic logic [WB-1:0] ring_next(input logic [WB-1:0] v);
		ring_next = (32'(v) + 1 >= NUM_WORKERS) ? '0 : WB'(32'(v) + 1);
	endfunction

	function automatic logic [QB-1:0] qwrap(input logic [QB:0] v);
		qwrap = (32'(v) >= QUEUE_DEPTH) ? QB'(32'(v) - QUEUE_DEPTH) : QB'(v);
	endfunction

	always_comb begin
		pend = 1'b0;
		for (int i = 0; i < NUM_WORKERS; i++) pend |= (count_q[i] != '0);
	end

	assign widx_ext = (WB + 1)'(q_word.worker_index);

	// index is below 4 and there are at least two workers: one subtract wraps it
	assign widx_base = (32'(widx_ext) < NUM_WORKERS) ? WB'(widx_ext) :
		WB'(32'(widx_ext) - NUM_WORKERS);

	always_comb begin
		st_d = st_q; probe_d = probe_q; used_d = used_q; left_d = left_q;
		stl_d = stl_q; acc_d = acc_q;
		q_pop = 1'b0; take = 1'b0; take_back = 1'b0; do_enq = 1'b0;
		own_ok = 1'b0;
		rd_en = 1'b0; rd_addr = '0;
		wr_addr = {target_q, qwrap({1'b0, head_q[target_q]} + (QB + 1)'(count_q[target_q]))};
		slot = '0;
		unique case (st_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					stl_d = 1'b0; acc_d = 1'b0; used_d = '0;
					if (q_word.mode == MODE_ENQ) begin
						do_enq = 1'b1;
						used_d = target_q;
						acc_d = (32'(count_q[target_q]) < QUEUE_DEPTH);
						st_d = ST_DONE;
					end else begin
						own_ok = (32'(widx_ext) < NUM_WORKERS) &&
							(count_q[WB'(q_word.worker_index)] != '0);
						if (own_ok) begin
							take = 1'b1;
							used_d = WB'(q_word.worker_index);
							acc_d = 1'b1;
							rd_en = 1'b1;
							rd_addr = {used_d, head_q[used_d]};
							st_d = ST_READ;
						end else begin
							probe_d = ring_next(widx_base);
							left_d = (32'(widx_ext) < NUM_WORKERS) ?
								(WB + 1)'(NUM_WORKERS - 1) : (WB + 1)'(NUM_WORKERS);
							st_d = ST_PROBE;
						end
					end
				end
			end
			ST_PROBE: begin
				if (left_q == '0) begin
					st_d = ST_DONE;
				end else if (count_q[probe_q] != '0) begin
					take_back = 1'b1;
					used_d = probe_q; acc_d = 1'b1; stl_d = 1'b1;
					slot = qwrap({1'b0, head_q[probe_q]} + (QB + 1)'(count_q[probe_q] - 1'b1));
					rd_en = 1'b1;
					rd_addr = {probe_q, slot};
					st_d = ST_READ;
				end else begin
					probe_d = ring_next(probe_q);
					left_d = left_q - 1'b1;
				end
			end
			ST_READ: st_d = ST_DONE;
			ST_DONE: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (do_enq && acc_d) store_q[wr_addr] <= q_word.task_id;
		if (rd_en) rd_data_q <= store_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		cmd_q <= (st_q == ST_IDLE) ? q_word : cmd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; target_q <= '0;
			probe_q <= '0; used_q <= '0; left_q <= '0; stl_q <= 1'b0; acc_q <= 1'b0;
			for (int i = 0; i < NUM_WORKERS; i++) begin
				head_q[i] <= '0; count_q[i] <= '0;
			end
		end else begin
			st_q <= st_d; probe_q <= probe_d; used_q <= used_d; left_q <= left_d;
			stl_q <= stl_d; acc_q <= acc_d;
			if (do_enq) begin
				target_q <= ring_next(target_q);
				if (acc_d) count_q[target_q] <= count_q[target_q] + 1'b1;
			end
			if (take) begin
				head_q[used_d] <= qwrap({1'b0, head_q[used_d]} + 1'b1);
				count_q[used_d] <= count_q[used_d] - 1'b1;
			end
			if (take_back) count_q[probe_q] <= count_q[probe_q] - 1'b1;
		end
	end

	assign done = (st_q == ST_DONE);
	always_comb begin
		result.accepted    = acc_q;
		result.task_out    = (acc_q && cmd_q.mode == MODE_FETCH) ? rd_data_q : 16'd0;
		result.queue_used  = 2'(used_q);
		result.stolen      = stl_q;
		result.any_pending = pend;
	end

endmodule

// File: src/work_stealing_task_dispatch.sv
// ----------------------------------------------------------------------------
// work_stealing_task_dispatch: per-worker task queues with stealing
// Back end state sequence per word: enqueue IDLE, DONE; own fetch IDLE, READ,
// DONE; steal IDLE, PROBE, READ, DONE; miss IDLE, PROBE, DONE (probe visits one
// queue per cycle). The back end pops a word only in IDLE, one word at a time.
// The two-word front queue raises busy only when full.
// Asynchronous reset empties all queues; the task store is not cleared.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module work_stealing_task_dispatch #(
	parameter int NUM_WORKERS  = wstd_pkg::NUM_WORKERS_DEF,
	parameter int QUEUE_DEPTH  = wstd_pkg::QUEUE_DEPTH_DEF,
	parameter int TASK_ID_BITS = wstd_pkg::TASK_ID_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  wstd_pkg::in_word_t  in_word,
	output logic                busy,
	output logic                done,
	output wstd_pkg::out_word_t result
);
	import wstd_pkg::*;

	logic     q_valid, q_pop;
	in_word_t q_word;

	wstd_front #(.TASK_ID_BITS(TASK_ID_BITS)) u_front (
		.clk, .arst_n, .start, .in_word, .busy, .q_valid, .q_word, .q_pop
	);

	wstd_back #(.NUM_WORKERS(NUM_WORKERS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk, .arst_n, .q_valid, .q_word, .q_pop, .done, .result
	);

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for work_stealing_task_dispatch
// Directed and random enqueue/fetch words; a local queue model predicts each
// result word, which is compared field by field with the strobed output.
// ----------------------------------------------------------------------------
module tb_top;
	import wstd_pkg::*;

	localparam int NW = 4;
	localparam int QD = 16;
	localparam int EXP_DEPTH = 1024;

	logic      clk;
	logic      arst_n;
	logic      start;
	in_word_t  in_word;
	logic      busy;
	logic      done;
	out_word_t result;

	logic [15:0] mdl_store [NW][QD];
	logic [3:0]  mdl_head [NW];
	int          mdl_count [NW];
	logic [1:0]  mdl_target;
	out_word_t   exp_mem [EXP_DEPTH];
	int          exp_wr;
	int          exp_rd;
	int          err_cnt;

	work_stealing_task_dispatch u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .in_word(in_word),
		.busy(busy), .done(done), .result(result)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		err_cnt++;
	endtask

	function automatic out_word_t dispatch_predict(input in_word_t w);
		out_word_t r;
		int t, v, slot;
		r = '0;
		if (w.mode == MODE_ENQ) begin
			t = mdl_target;
			mdl_target = mdl_target + 2'd1;
			r.queue_used = t[1:0];
			if (mdl_count[t] < QD) begin
				slot = (mdl_head[t] + mdl_count[t]) % QD;
				mdl_store[t][slot] = w.task_id;
				mdl_count[t]++;
				r.accepted = 1'b1;
			end
		end else if (mdl_count[w.worker_index] != 0) begin
			t = w.worker_index;
			r.task_out = mdl_store[t][mdl_head[t]];
			mdl_head[t] = mdl_head[t] + 4'd1;
			mdl_count[t]--;
			r.queue_used = t[1:0];
			r.accepted = 1'b1;
		end else begin
			for (int off = 1; off < NW; off++) begin
				v = (w.worker_index + off) % NW;
				if (mdl_count[v] != 0 && !r.accepted) begin
					slot = (mdl_head[v] + mdl_count[v] - 1) % QD;
					mdl_count[v]--;
					r.task_out = mdl_store[v][slot];
					r.queue_used = v[1:0];
					r.accepted = 1'b1;
					r.stolen = 1'b1;
				end
			end
		end
		for (int q = 0; q < NW; q++)
			if (mdl_count[q] != 0) r.any_pending = 1'b1;
		return r;
	endfunction

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 2);
		repeat (n) @(posedge clk);
	endtask

	task automatic send_word(input logic m, input logic [15:0] id, input logic [1:0] wi,
			input bit gaps);
		in_word_t w;
		bit       taken;
		w.mode = m;
		w.task_id = id;
		w.worker_index = wi;
		start <= 1'b1;
		in_word <= w;
		// busy only moves at rising edges, so the mid-cycle value is the one at the edge
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		exp_mem[exp_wr % EXP_DEPTH] = dispatch_predict(w);
		exp_wr++;
		if (gaps && $urandom_range(0, 1)) begin
			start <= 1'b0;
			idle_gap();
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// received words checked in order
	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && done) begin
			if (exp_wr == exp_rd) begin
				report_mismatch("unexpected result word", 1, 0);
			end else begin
				e = exp_mem[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (result.accepted !== e.accepted)
					report_mismatch("accepted", result.accepted, e.accepted);
				if (result.task_out !== e.task_out)
					report_mismatch("task_out", result.task_out, e.task_out);
				if (result.queue_used !== e.queue_used)
					report_mismatch("queue_used", result.queue_used, e.queue_used);
				if (result.stolen !== e.stolen)
					report_mismatch("stolen", result.stolen, e.stolen);
				if (result.any_pending !== e.any_pending)
					report_mismatch("any_pending", result.any_pending, e.any_pending);
			end
		end
	end

	task automatic test_empty_fetch();
		for (int i = 0; i < NW; i++) send_word(MODE_FETCH, 16'hFFFF, i[1:0], 1'b0);
		drain();
	endtask

	task automatic test_fill_and_drop();
		// overfill all four queues: 16 rounds fill them, then the 17th round is dropped
		for (int i = 0; i < NW * QD + 4; i++)
			send_word(MODE_ENQ, (i[0]) ? 16'hFFFF : 16'h0000 + i[15:0], 2'd3, 1'b0);
		drain();
	endtask

	task automatic test_own_and_steal();
		for (int i = 0; i < QD; i++) send_word(MODE_FETCH, 16'h0, 2'd0, 1'b0);
		send_word(MODE_FETCH, 16'h0, 2'd0, 1'b0);
		send_word(MODE_FETCH, 16'h0, 2'd3, 1'b0);
		drain();
		// empty everything through worker 1
		for (int i = 0; i < NW * QD; i++) send_word(MODE_FETCH, 16'h0, 2'd1, 1'b0);
		send_word(MODE_FETCH, 16'h0, 2'd2, 1'b0);
		drain();
	endtask

	task automatic test_random();
		for (int i = 0; i < 400; i++) begin
			send_word($urandom_range(0, 99) < 52, 16'($urandom_range(0, 65535)),
				2'($urandom_range(0, 3)), 1'b1);
			if (i == 200) drain();
		end
		drain();
	endtask

	initial begin
		err_cnt = 0;
		exp_wr = 0;
		exp_rd = 0;
		start = 1'b0;
		in_word = '0;
		arst_n = 1'b0;
		mdl_target = '0;
		for (int q = 0; q < NW; q++) begin
			mdl_head[q] = '0;
			mdl_count[q] = 0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_fetch();
		test_fill_and_drop();
		test_own_and_steal();
		test_random();
		if (err_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#2ms;
		$display("status: fail");
		$finish;
	end

endmodule
